[design/dpf_pkg.sv]
// ----------------------------------------------------------------------------
// dpf_pkg: shared types and constants for the derivative peak finder
// Field widths, register codes, result kinds and the structs passed between
// the configuration block, the slope lanes and the top level.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WAVE_W      = 17;  // baseline minus sample
  localparam int SLOPE_W     = 20;  // 2w[i] - w[i-r] - w[i-r-1]
  localparam int THR_W       = 19;
  localparam int RISE_LEN_W  = 4;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_INDEX_W = 3;
  localparam int POS_W       = 16;
  localparam int COUNT_W     = 7;
  localparam int KIND_W      = 2;
  localparam int CMP_W       = 22;  // common compare width, holds every difference

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASELINE        = 3'd0,
    CFG_RISE_LEN        = 3'd1,
    CFG_SLOPE_THRESHOLD = 3'd2,
    CFG_CURVE_THRESHOLD = 3'd3,
    CFG_RISE_THRESHOLD  = 3'd4
  } dpf_cfg_index_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NEW     = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_END     = 2'd2
  } dpf_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] baseline;
    logic [RISE_LEN_W-1:0]      rise_len;
    logic [THR_W-1:0]           slope_thr;
    logic [THR_W-1:0]           curve_thr;
    logic [THR_W-1:0]           rise_thr;
  } dpf_cfg_t;

  typedef struct packed {
    logic step;   // shift a new sample into the histories
    logic clear;  // end of waveform: return histories to zero
    logic inwin;  // sample lies inside the detection window
  } dpf_lane_ctrl_t;

endpackage

[design/dpf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dpf_cfg_regs: configuration register file
// Plain write port, no read-back. Also clamps rise_len to 1..MAX_RISE.
// ----------------------------------------------------------------------------
module dpf_cfg_regs #(
  parameter int MAX_RISE = 8,
  localparam int RL_W = $clog2(MAX_RISE + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dpf_pkg::dpf_cfg_t                cfg,
  output logic [RL_W-1:0]                  rl_eff
);
  import dpf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline  <= '0;
      cfg.rise_len  <= RISE_LEN_W'(3);
      cfg.slope_thr <= '0;
      cfg.curve_thr <= '0;
      cfg.rise_thr  <= '0;
    end else if (cfg_we) begin
      case (dpf_cfg_index_t'(cfg_index))
        CFG_BASELINE:        cfg.baseline  <= cfg_data[SAMPLE_W-1:0];
        CFG_RISE_LEN:        cfg.rise_len  <= cfg_data[RISE_LEN_W-1:0];
        CFG_SLOPE_THRESHOLD: cfg.slope_thr <= cfg_data[THR_W-1:0];
        CFG_CURVE_THRESHOLD: cfg.curve_thr <= cfg_data[THR_W-1:0];
        CFG_RISE_THRESHOLD:  cfg.rise_thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything past the lane count as the top lane
  always_comb begin
    if (cfg.rise_len == '0) begin
      rl_eff = RL_W'(1);
    end else if (int'(cfg.rise_len) > MAX_RISE) begin
      rl_eff = RL_W'(MAX_RISE);
    end else begin
      rl_eff = RL_W'(cfg.rise_len);
    end
  end

endmodule

[design/dpf_slope_lanes.sv]
// ----------------------------------------------------------------------------
// dpf_slope_lanes: wave history and one slope lane per rise length
// Each lane forms its slope numerator, compares slope, curve and rise against
// the thresholds and keeps its own slope delay line r samples deep.
// ----------------------------------------------------------------------------
module dpf_slope_lanes #(
  parameter int MAX_RISE = 8,
  localparam int RL_W = $clog2(MAX_RISE + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dpf_pkg::dpf_lane_ctrl_t             ctrl,
  input  logic signed [dpf_pkg::WAVE_W-1:0]   w_new,
  input  logic [RL_W-1:0]                     rl,
  input  dpf_pkg::dpf_cfg_t                   cfg,
  output logic [RL_W-1:0]                     big
);
  import dpf_pkg::*;

  // wave_hist[k] holds w[i-1-k]
  logic signed [WAVE_W-1:0] wave_hist [MAX_RISE+1];
  logic [MAX_RISE-1:0]      fire;
  logic signed [CMP_W-1:0]  w0x;
  logic signed [CMP_W-1:0]  slope_thr_x;
  logic signed [CMP_W-1:0]  curve_thr_x;
  logic signed [CMP_W-1:0]  rise_thr_x;

  assign w0x         = {{(CMP_W-WAVE_W){w_new[WAVE_W-1]}}, w_new};
  assign slope_thr_x = CMP_W'(cfg.slope_thr);
  assign curve_thr_x = CMP_W'(cfg.curve_thr);
  assign rise_thr_x  = CMP_W'(cfg.rise_thr);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int k = 0; k <= MAX_RISE; k++) wave_hist[k] <= '0;
    end else if (ctrl.step) begin
      for (int k = MAX_RISE; k > 0; k--) wave_hist[k] <= wave_hist[k-1];
      wave_hist[0] <= w_new;
    end
  end

  for (genvar g = 1; g <= MAX_RISE; g++) begin : g_lane
    logic signed [SLOPE_W-1:0] slope_hist [g];  // slope_hist[g-1] is r samples back
    logic signed [CMP_W-1:0]   wr;
    logic signed [CMP_W-1:0]   wr1;
    logic signed [CMP_W-1:0]   old_slope;
    logic signed [CMP_W-1:0]   slope;
    logic signed [CMP_W-1:0]   curve;
    logic signed [CMP_W-1:0]   rise;
    logic                      lane_on;
    logic signed [SLOPE_W-1:0] slope_store;

    assign wr        = {{(CMP_W-WAVE_W){wave_hist[g-1][WAVE_W-1]}}, wave_hist[g-1]};
    assign wr1       = {{(CMP_W-WAVE_W){wave_hist[g][WAVE_W-1]}}, wave_hist[g]};
    assign old_slope = {{(CMP_W-SLOPE_W){slope_hist[g-1][SLOPE_W-1]}}, slope_hist[g-1]};
    assign slope     = (w0x <<< 1) - wr - wr1;
    assign curve     = slope - old_slope;
    assign rise      = w0x - wr;
    assign lane_on   = ctrl.inwin && (int'(rl) >= g);
    assign slope_store = lane_on ? slope[SLOPE_W-1:0] : '0;
    assign fire[g-1] = lane_on && (slope >= slope_thr_x) && (curve > curve_thr_x)
                       && (rise > rise_thr_x);

    always_ff @(posedge clk) begin
      if (rst || ctrl.clear) begin
        for (int k = 0; k < g; k++) slope_hist[k] <= '0;
      end else if (ctrl.step) begin
        for (int k = g - 1; k > 0; k--) slope_hist[k] <= slope_hist[k-1];
        slope_hist[0] <= slope_store;
      end
    end
  end

  // largest rise length that fired, zero when none
  always_comb begin
    big = '0;
    for (int r = 0; r < MAX_RISE; r++) begin
      if (fire[r]) big = RL_W'(r + 1);
    end
  end

endmodule

[design/derivative_peak_finder_core.sv]
// ----------------------------------------------------------------------------
// Path: a sample beat passes the input register, then one pass of lane logic
//   into the result register; a stalled result holds it in the input register.
// Throughput: one sample beat per cycle while the result channel does not stall.
// Reset: rst is synchronous, active high; it clears configuration to its
//   defaults (rise_len 3, all else zero) and all per-waveform history.
// ----------------------------------------------------------------------------
// derivative_peak_finder_core: multi-rise derivative peak finder
// Inverts each sample against the baseline, tests every rise length for
// slope, curve and rise, and reports new peaks, replaced peaks and an end
// record carrying the peak count on the last sample of a waveform.
// ----------------------------------------------------------------------------
module derivative_peak_finder_core #(
  parameter int MAX_RISE    = 8,
  parameter int MAX_PEAKS   = 100,
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [dpf_pkg::SAMPLE_W-1:0] sample,
  input  logic                               end_of_wave,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [dpf_pkg::KIND_W-1:0]         kind,
  output logic [dpf_pkg::POS_W-1:0]          peak_position,
  output logic signed [dpf_pkg::SAMPLE_W-1:0] peak_height,
  output logic [dpf_pkg::COUNT_W-1:0]        peak_count
);
  import dpf_pkg::*;

  localparam int RL_W  = $clog2(MAX_RISE + 1);
  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int FC_W  = $clog2(MAX_PEAKS + 1);

  dpf_cfg_t               cfg;
  logic [RL_W-1:0]        rl_eff;

  // input register
  logic                   in_full;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                   in_eow;
  logic signed [WAVE_W-1:0] in_wave;

  // per-waveform bookkeeping
  logic [IDX_W-1:0]       sample_index;
  logic [IDX_W-1:0]       last_peak;
  logic [FC_W-1:0]        found;
  logic                   stopped;

  logic                   sample_take;
  logic                   out_free;
  logic                   proc;
  logic                   inwin;
  logic                   active;
  logic                   hit;
  logic                   is_new;
  logic [IDX_W-1:0]       diff;
  logic [FC_W-1:0]        found_next;
  logic [RL_W-1:0]        big;
  logic [31:0]            idx_wide;
  logic [31:0]            found_next_wide;
  logic [31:0]            found_wide;
  dpf_lane_ctrl_t         lane_ctrl;

  dpf_cfg_regs #(.MAX_RISE(MAX_RISE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .rl_eff    (rl_eff)
  );

  // The result register frees itself when its beat is taken; the held input
  // beat then moves through the lanes in the same cycle.
  assign out_free     = !result_valid || !result_stall;
  assign proc         = in_full && out_free;
  assign sample_stall = in_full && !out_free;
  assign sample_take  = sample_valid && !sample_stall;

  // Capture the beat and invert it against the baseline straight away, so the
  // lane pass starts from a ready wave value.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_take) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      in_sample <= sample;
      in_eow    <= end_of_wave;
      in_wave   <= WAVE_W'(cfg.baseline) - WAVE_W'(sample);
    end
  end

  // Detection window: indices past the rise length, below the sample cap,
  // and only while the peak limit has not been reached.
  assign inwin  = sample_index >= (IDX_W'(rl_eff) + IDX_W'(1));
  assign active = inwin && !stopped && (sample_index < IDX_W'(MAX_SAMPLES));

  assign lane_ctrl.step  = proc && !in_eow;
  assign lane_ctrl.clear = proc && in_eow;
  assign lane_ctrl.inwin = inwin;

  dpf_slope_lanes #(.MAX_RISE(MAX_RISE)) u_lanes (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .w_new (in_wave),
    .rl    (rl_eff),
    .cfg   (cfg),
    .big   (big)
  );

  // A peak within R samples of the last one replaces it; the first
  // peak of a waveform is always new, so the last index needs no reset.
  assign hit        = active && (big != '0);
  assign diff       = sample_index - last_peak;
  assign is_new     = (found == '0) || (diff > IDX_W'(big));
  assign found_next = is_new ? found + FC_W'(1) : found;

  assign idx_wide        = 32'(sample_index);
  assign found_next_wide = 32'(found_next);
  assign found_wide      = 32'(found);

  // Bookkeeping: advance the index, count peaks, stop at the peak limit,
  // and drop everything back to its start values on the end beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      found        <= '0;
      stopped      <= 1'b0;
    end else if (proc) begin
      if (in_eow) begin
        sample_index <= '0;
        found        <= '0;
        stopped      <= 1'b0;
      end else begin
        if (sample_index < IDX_W'(MAX_SAMPLES)) sample_index <= sample_index + IDX_W'(1);
        if (hit) begin
          found <= found_next;
          if (found_next >= FC_W'(MAX_PEAKS)) stopped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !in_eow && hit) last_peak <= sample_index;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc && (in_eow || hit)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      if (in_eow) begin
        kind          <= KIND_END;
        peak_position <= '0;
        peak_height   <= '0;
        peak_count    <= found_wide[COUNT_W-1:0];
      end else if (hit) begin
        kind          <= is_new ? KIND_NEW : KIND_REPLACE;
        peak_position <= idx_wide[POS_W-1:0];
        peak_height   <= in_sample;
        peak_count    <= found_next_wide[COUNT_W-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_at_limit: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (found >= FC_W'(MAX_PEAKS)))
    else $error("search stopped below the peak limit");

  a_index_capped: assert property (@(posedge clk) disable iff (rst)
    sample_index <= IDX_W'(MAX_SAMPLES))
    else $error("sample index ran past its cap");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && in_eow) |=> (sample_index == '0 && found == '0 && !stopped))
    else $error("per-waveform state not cleared after end beat");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> in_full)
    else $error("sample channel stalled with empty input register");
`endif

endmodule
